[rtl/fmprc_pkg.sv]
package fmprc_pkg;

  localparam int unsigned MaxRulesDefault  = 64;
  localparam int unsigned NumChainsDefault = 8;
  localparam int unsigned ChainW           = 3;
  localparam int unsigned SlotW            = 6;
  localparam int unsigned CtrlW            = 13;
  localparam int unsigned CfgIdxW          = 1;
  localparam int unsigned CfgDataW         = 24;
  localparam logic [23:0] DefaultActionsRst = 24'd65;
  localparam logic [3:0]  ActiveChainsRst   = 4'd5;

  typedef enum logic [1:0] {
    ModeWrite = 2'd0,
    ModeCount = 2'd1,
    ModeClass = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    WordSrc  = 2'd0,
    WordDst  = 2'd1,
    WordPort = 2'd2,
    WordCtrl = 2'd3
  } word_e;

  typedef enum logic [0:0] {
    CfgDefaultActions = 1'b0,
    CfgActiveChains   = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCheck,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic absent;
    logic is_class;
    logic scan_end;
    logic match;
  } sts_t;

endpackage

[rtl/fmprc_datapath.sv]
module fmprc_datapath #(
  parameter int unsigned MaxRules  = fmprc_pkg::MaxRulesDefault,
  parameter int unsigned NumChains = fmprc_pkg::NumChainsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_index_i,
  input  logic [23:0]             cfg_data_i,
  input  fmprc_pkg::cmd_t         cmd_i,
  output fmprc_pkg::sts_t         sts_o,
  input  logic [1:0]              mode_i,
  input  logic [2:0]              chain_index_i,
  input  logic [5:0]              rule_slot_i,
  input  logic [1:0]              word_select_i,
  input  logic [63:0]             word_data_i,
  input  logic [31:0]             src_address_i,
  input  logic [31:0]             dst_address_i,
  input  logic [15:0]             src_port_num_i,
  input  logic [15:0]             dst_port_num_i,
  input  logic [7:0]              protocol_num_i,
  output logic [2:0]              action_code_o,
  output logic                    hit_o,
  output logic [5:0]              hit_rule_o,
  output logic                    status_o
);
  import fmprc_pkg::*;

  localparam int unsigned RuleW  = (MaxRules > 1) ? $clog2(MaxRules) : 1;
  localparam int unsigned CntW   = $clog2(MaxRules + 1);
  localparam int unsigned CIdxW  = (NumChains > 1) ? $clog2(NumChains) : 1;
  localparam int unsigned Depth  = NumChains * MaxRules;
  localparam int unsigned AddrW  = $clog2(Depth) > 0 ? $clog2(Depth) : 1;

  logic [63:0] src_mem  [Depth];
  logic [63:0] dst_mem  [Depth];
  logic [63:0] port_mem [Depth];
  logic [CtrlW-1:0] ctrl_mem [Depth];
  logic [CntW-1:0] count_q [NumChains];

  logic [23:0] def_q;
  logic [3:0]  act_q;

  logic [1:0]  mode_q;
  logic [2:0]  chain_q;
  logic [5:0]  slot_q;
  logic [1:0]  sel_q;
  logic [63:0] data_q;
  logic [31:0] sa_q, da_q;
  logic [15:0] sp_q, dp_q;
  logic [7:0]  pr_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] n_q;

  logic [63:0] src_r, dst_r, port_r;
  logic [CtrlW-1:0] ctrl_r;
  logic [RuleW-1:0] rule_idx_q;

  logic [2:0] act_o_q;
  logic       hit_q, status_q;
  logic [5:0] rule_o_q;

  logic [3:0] limit;
  logic       absent;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic       match;
  logic [2:0] def_action;

  always_comb begin
    limit = (act_q < 4'(NumChains)) ? act_q : 4'(NumChains);
    absent = (mode_q != ModeNone) && ({1'b0, chain_q} >= limit);
  end

  always_comb begin
    wr_addr = AddrW'(32'(chain_q[CIdxW-1:0]) * MaxRules + 32'(slot_q));
    rd_addr = AddrW'(32'(chain_q[CIdxW-1:0]) * MaxRules + 32'(idx_q[RuleW-1:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q <= DefaultActionsRst;
      act_q <= ActiveChainsRst;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CfgDefaultActions: def_q <= cfg_data_i;
        CfgActiveChains:   act_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      chain_q <= chain_index_i;
      slot_q  <= rule_slot_i;
      sel_q   <= word_select_i;
      data_q  <= word_data_i;
      sa_q    <= src_address_i;
      da_q    <= dst_address_i;
      sp_q    <= src_port_num_i;
      dp_q    <= dst_port_num_i;
      pr_q    <= protocol_num_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en && !absent && mode_q == ModeWrite && 32'(slot_q) < MaxRules) begin
      case (word_e'(sel_q))
        WordSrc:  src_mem[wr_addr]  <= data_q;
        WordDst:  dst_mem[wr_addr]  <= data_q;
        WordPort: port_mem[wr_addr] <= data_q;
        WordCtrl: ctrl_mem[wr_addr] <= data_q[CtrlW-1:0];
        default: ;
      endcase
    end
    if (cmd_i.rd_en) begin
      src_r      <= src_mem[rd_addr];
      dst_r      <= dst_mem[rd_addr];
      port_r     <= port_mem[rd_addr];
      ctrl_r     <= ctrl_mem[rd_addr];
      rule_idx_q <= idx_q[RuleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChains; i++) count_q[i] <= '0;
    end else if (cmd_i.rd_en && !absent && mode_q == ModeCount) begin
      count_q[chain_q[CIdxW-1:0]] <= (32'(data_q[6:0]) > MaxRules) ?
                                     CntW'(MaxRules) : CntW'(data_q[6:0]);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) idx_d = '0;
    else if (cmd_i.advance) idx_d = idx_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      n_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.load) n_q <= count_q[chain_index_i[CIdxW-1:0]];
    end
  end

  function automatic logic addr_ok(input logic [31:0] pkt, input logic [63:0] w);
    logic [31:0] a, m;
    a = w[63:32];
    m = w[31:0];
    return (a == '0) || (m == '0) || ((pkt & m) == (a & m));
  endfunction

  function automatic logic port_ok(input logic [15:0] p, input logic [15:0] lo,
                                   input logic [15:0] hi);
    return ((lo == '0) && (hi == '0)) || ((p >= lo) && (p <= hi));
  endfunction

  always_comb begin
    match = ctrl_r[0] && (ctrl_r[12] || ctrl_r[11:4] == pr_q) &&
            addr_ok(sa_q, src_r) && addr_ok(da_q, dst_r) &&
            port_ok(sp_q, port_r[63:48], port_r[47:32]) &&
            port_ok(dp_q, port_r[31:16], port_r[15:0]);
    def_action = 3'(def_q >> (3 * chain_q));
  end

  // A rule counts only when its position lies inside the chain's rule count.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      act_o_q  <= '0;
      hit_q    <= 1'b0;
      rule_o_q <= '0;
      status_q <= absent;
      if (!absent && mode_q == ModeClass) begin
        if (sts_o.match && (CntW'(rule_idx_q) < n_q)) begin
          act_o_q  <= ctrl_r[3:1];
          hit_q    <= 1'b1;
          rule_o_q <= 6'(rule_idx_q);
        end else begin
          act_o_q <= def_action;
        end
      end
    end
  end

  assign sts_o.absent   = absent;
  assign sts_o.is_class = (mode_q == ModeClass);
  assign sts_o.scan_end = (idx_q >= n_q);
  assign sts_o.match    = match;

  assign action_code_o = act_o_q;
  assign hit_o         = hit_q;
  assign hit_rule_o    = rule_o_q;
  assign status_o      = status_q;

endmodule

[rtl/fmprc_ctrl.sv]
module fmprc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  fmprc_pkg::sts_t sts_i,
  output fmprc_pkg::cmd_t cmd_o
);
  import fmprc_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ov_d       = ov_q;
    cmd_o      = '0;
    in_ready_o = (state_q == StIdle);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRead;
        end
      end
      StRead: begin
        // Performs writes and count updates, or reads the next rule.
        cmd_o.rd_en = 1'b1;
        if (!sts_i.is_class || sts_i.absent || sts_i.scan_end) begin
          state_d = StDone;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.match) begin
          state_d = StDone;
        end else if (sts_i.scan_end) begin
          state_d = StDone;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.advance = 1'b1;
        end
      end
      StDone: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          ov_d         = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

[rtl/first_match_packet_rule_classifier.sv]
// Writes, count updates and absent chains pass through the idle, read and done
// states; a classify also scans rules in the check state (one rule per cycle).
// A new item is taken only once the last has finished; a stalled output holds it in done.
// A finished result waits in the output register while the next item enters.
// Reset is asynchronous, active low; rule counts clear, rule words do not.
module first_match_packet_rule_classifier #(
  parameter int unsigned MaxRules  = fmprc_pkg::MaxRulesDefault,
  parameter int unsigned NumChains = fmprc_pkg::NumChainsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  chain_index_i,
  input  logic [5:0]  rule_slot_i,
  input  logic [1:0]  word_select_i,
  input  logic [63:0] word_data_i,
  input  logic [31:0] src_address_i,
  input  logic [31:0] dst_address_i,
  input  logic [15:0] src_port_num_i,
  input  logic [15:0] dst_port_num_i,
  input  logic [7:0]  protocol_num_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_code_o,
  output logic        hit_o,
  output logic [5:0]  hit_rule_o,
  output logic        status_o
);
  import fmprc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fmprc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  fmprc_datapath #(.MaxRules(MaxRules), .NumChains(NumChains)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts),
    .mode_i, .chain_index_i, .rule_slot_i, .word_select_i, .word_data_i,
    .src_address_i, .dst_address_i, .src_port_num_i, .dst_port_num_i,
    .protocol_num_i, .action_code_o, .hit_o, .hit_rule_o, .status_o
  );

endmodule

[rtl/fmprc_checker.sv]
module fmprc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] action_code_o,
  input logic       hit_o,
  input logic [5:0] hit_rule_o,
  input logic       status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_code_o))
    else $error("result dropped while stalled");

  a_no_hit_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_rule_o == 6'd0)
    else $error("rule position without hit");

  a_absent_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !hit_o && action_code_o == 3'd0)
    else $error("absent chain with action");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted two items back to back");

endmodule

bind first_match_packet_rule_classifier fmprc_checker u_fmprc_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fmprc_pkg::*;

  localparam int unsigned MaxRules = 64;
  localparam int unsigned NumChains = 8;
  localparam int unsigned Depth = MaxRules * NumChains;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct packed {
    logic [2:0] action;
    logic       hit;
    logic [5:0] pos;
    logic       status;
  } verdict_t;

  typedef struct {
    mode_e       mode;
    logic [2:0]  chain;
    logic [5:0]  slot;
    word_e       sel;
    logic [63:0] data;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
  } request_t;

  typedef struct {
    request_t req;
    logic     has_exp;
    verdict_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [2:0] chain_index_i = '0;
  logic [5:0] rule_slot_i = '0;
  logic [1:0] word_select_i = '0;
  logic [63:0] word_data_i = '0;
  logic [31:0] src_address_i = '0;
  logic [31:0] dst_address_i = '0;
  logic [15:0] src_port_num_i = '0;
  logic [15:0] dst_port_num_i = '0;
  logic [7:0] protocol_num_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] action_code_o;
  logic hit_o;
  logic [5:0] hit_rule_o;
  logic status_o;

  first_match_packet_rule_classifier DUT (.*);

  always #5 clk_i = ~clk_i;

  logic [23:0] dflt_actions;
  logic [3:0]  chain_limit;
  logic [63:0] src_tbl [Depth];
  logic [63:0] dst_tbl [Depth];
  logic [63:0] port_tbl [Depth];
  logic [12:0] ctrl_tbl [Depth];
  logic [6:0]  count_tbl [NumChains];
  logic [MaxRules-1:0] written [NumChains];
  logic [3:0]  words_seen [NumChains][MaxRules];

  verdict_t pending_verdicts[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit quiet = 1'b0;

  function automatic bit addr_match(logic [31:0] pkt, logic [63:0] w);
    if (w[63:32] == 0 || w[31:0] == 0) return 1'b1;
    return (pkt & w[31:0]) == (w[63:32] & w[31:0]);
  endfunction

  function automatic bit port_match(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
    if (lo == 0 && hi == 0) return 1'b1;
    return p >= lo && p <= hi;
  endfunction

  function automatic verdict_t classify(request_t r);
    verdict_t v;
    int unsigned lim;
    int unsigned a;
    logic [12:0] c;
    v = '0;
    lim = chain_limit < NumChains ? chain_limit : NumChains;
    if (r.mode != ModeNone && r.chain >= lim) begin
      v.status = 1'b1;
    end else if (r.mode == ModeWrite) begin
      a = r.chain * MaxRules + r.slot;
      case (r.sel)
        WordSrc: src_tbl[a] = r.data;
        WordDst: dst_tbl[a] = r.data;
        WordPort: port_tbl[a] = r.data;
        default: ctrl_tbl[a] = r.data[12:0];
      endcase
      words_seen[r.chain][r.slot][r.sel] = 1'b1;
      if (&words_seen[r.chain][r.slot]) written[r.chain][r.slot] = 1'b1;
    end else if (r.mode == ModeCount) begin
      count_tbl[r.chain] = r.data[6:0] > MaxRules ? 7'(MaxRules) : r.data[6:0];
    end else if (r.mode == ModeClass) begin
      v.action = dflt_actions[3*r.chain +: 3];
      for (int i = 0; i < count_tbl[r.chain]; i++) begin
        a = r.chain * MaxRules + i;
        c = ctrl_tbl[a];
        if (!c[0]) continue;
        if (!c[12] && c[11:4] != r.proto) continue;
        if (!addr_match(r.sa, src_tbl[a]) || !addr_match(r.da, dst_tbl[a])) continue;
        if (!port_match(r.sp, port_tbl[a][63:48], port_tbl[a][47:32])) continue;
        if (!port_match(r.dp, port_tbl[a][31:16], port_tbl[a][15:0])) continue;
        v.action = c[3:1];
        v.hit = 1'b1;
        v.pos = 6'(i);
        break;
      end
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{action_code_o, hit_o, hit_rule_o, status_o};
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_cfg(cfg_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgDefaultActions) dflt_actions = val;
    else chain_limit = val[3:0];
  endtask

  task automatic drain;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic issue(request_t r, logic has_exp, verdict_t exp);
    verdict_t v;
    if (!quiet && $urandom_range(4) == 0) repeat ($urandom_range(1, 7)) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    chain_index_i <= r.chain;
    rule_slot_i <= r.slot;
    word_select_i <= r.sel;
    word_data_i <= r.data;
    src_address_i <= r.sa;
    dst_address_i <= r.da;
    src_port_num_i <= r.sp;
    dst_port_num_i <= r.dp;
    protocol_num_i <= r.proto;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    v = classify(r);
    if (has_exp && v !== exp) begin
      mismatches++;
      if (mismatches <= 10) $display("predictor disagrees with table: %p vs %p", v, exp);
    end
    pending_verdicts.push_back(v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic request_t rand_request(int unsigned lim);
    request_t r;
    int unsigned pick;
    logic [5:0] n;
    r.chain = 3'($urandom_range(7));
    if ($urandom_range(9) != 0) r.chain = 3'($urandom_range(lim - 1));
    r.slot = 6'($urandom);
    r.sel = word_e'($urandom_range(3));
    r.data = {$urandom, $urandom};
    r.sa = $urandom;
    r.da = $urandom;
    r.sp = 16'($urandom);
    r.dp = 16'($urandom);
    r.proto = 8'($urandom);
    pick = $urandom_range(19);
    if (pick < 11) r.mode = ModeClass;
    else if (pick < 17) r.mode = ModeWrite;
    else if (pick < 19) r.mode = ModeCount;
    else r.mode = ModeNone;
    if (r.mode == ModeWrite && $urandom_range(2) != 0) begin
      r.data = '0;
      case (r.sel)
        WordSrc, WordDst: begin
          r.data[63:32] = $urandom_range(1) ? $urandom : {24'hC0A800, 8'($urandom)};
          r.data[31:0] = $urandom_range(1) ? 32'hFFFFFF00 : ~32'h0 << $urandom_range(32);
        end
        WordPort: begin
          r.data[63:48] = 16'($urandom_range(2000));
          r.data[47:32] = r.data[63:48] + 16'($urandom_range(30000));
          r.data[31:16] = 16'($urandom_range(2000));
          r.data[15:0] = r.data[31:16] + 16'($urandom_range(30000));
          if ($urandom_range(3) == 0) r.data[63:32] = '0;
        end
        default: begin
          r.data[0] = $urandom_range(5) != 0;
          r.data[3:1] = 3'($urandom);
          r.data[11:4] = 8'($urandom_range(3) * 6);
          r.data[12] = 1'($urandom_range(1));
        end
      endcase
    end
    if (r.mode == ModeClass && $urandom_range(1)) begin
      r.sa = {24'hC0A800, 8'($urandom)};
      r.da = {24'hC0A800, 8'($urandom)};
      r.sp = 16'($urandom_range(4000));
      r.dp = 16'($urandom_range(4000));
      r.proto = 8'($urandom_range(3) * 6);
    end
    if (r.mode == ModeCount && r.chain < NumChains) begin
      n = '0;
      while (n < MaxRules - 1 && written[r.chain][n]) n++;
      if (written[r.chain][n] && n == MaxRules - 1) r.data[6:0] = 7'($urandom);
      else r.data[6:0] = 7'($urandom_range(n));
    end
    return r;
  endfunction

  task automatic fill_chain(int unsigned ch, int unsigned nrules);
    request_t r;
    r = '{ModeWrite, 3'(ch), '0, WordSrc, '0, '0, '0, '0, '0, '0};
    for (int s = 0; s < nrules; s++) begin
      r.slot = 6'(s);
      for (int w = 0; w < 4; w++) begin
        r.sel = word_e'(w);
        r.data = w == 3 ? 64'(13'h1001 | 13'(s % 8) << 1) : 64'h0;
        if (w == 2 && s != 0) r.data = {16'(s), 16'(s), 32'h0};
        issue(r, 1'b0, '0);
      end
    end
  endtask

  row_t directed[$];

  initial begin
    request_t r;
    verdict_t z;
    dflt_actions = DefaultActionsRst;
    chain_limit = ActiveChainsRst;
    for (int c = 0; c < NumChains; c++) begin
      count_tbl[c] = '0;
      written[c] = '0;
      for (int s = 0; s < MaxRules; s++) words_seen[c][s] = '0;
    end
    z = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    r = '{ModeClass, 3'd0, '0, WordSrc, '0, '0, '0, '0, '0, '0};
    directed.push_back('{r, 1'b1, '{3'd1, 1'b0, 6'd0, 1'b0}});
    r.chain = 3'd2;
    directed.push_back('{r, 1'b1, '{3'd1, 1'b0, 6'd0, 1'b0}});
    r.chain = 3'd7;
    directed.push_back('{r, 1'b1, '{3'd0, 1'b0, 6'd0, 1'b1}});
    r.mode = ModeWrite;
    r.chain = 3'd5;
    directed.push_back('{r, 1'b1, '{3'd0, 1'b0, 6'd0, 1'b1}});
    r.mode = ModeNone;
    r.chain = 3'd7;
    r.data = '1;
    directed.push_back('{r, 1'b1, z});
    r.mode = ModeCount;
    r.chain = 3'd6;
    directed.push_back('{r, 1'b1, '{3'd0, 1'b0, 6'd0, 1'b1}});
    r = '{ModeWrite, 3'd1, 6'd0, WordSrc, 64'hC0A80001_FFFFFF00, '0, '0, '0, '0, '0};
    directed.push_back('{r, 1'b1, z});
    r.sel = WordDst;
    r.data = 64'h0;
    directed.push_back('{r, 1'b1, z});
    r.sel = WordPort;
    r.data = {16'd10, 16'd20, 16'hFFFF, 16'hFFFF};
    directed.push_back('{r, 1'b1, z});
    r.sel = WordCtrl;
    r.data = '1;
    directed.push_back('{r, 1'b1, z});
    r.slot = 6'd1;
    r.data = 64'h0000_0000_0000_0065;
    directed.push_back('{r, 1'b1, z});
    r.sel = WordSrc;
    r.data = '0;
    directed.push_back('{r, 1'b1, z});
    r.sel = WordDst;
    directed.push_back('{r, 1'b1, z});
    r.sel = WordPort;
    r.data = {16'd5, 16'd4, 32'h0};
    directed.push_back('{r, 1'b1, z});
    r.mode = ModeCount;
    r.data = 64'h7F;
    directed.push_back('{r, 1'b0, z});
    r.data = 64'd2;
    directed.push_back('{r, 1'b1, z});
    r = '{ModeClass, 3'd1, '0, WordSrc, '0, 32'hC0A80055, '0, 16'd10, 16'hFFFF, 8'hFF};
    directed.push_back('{r, 1'b1, '{3'd7, 1'b1, 6'd0, 1'b0}});
    r.sp = 16'd21;
    directed.push_back('{r, 1'b1, '{3'd0, 1'b0, 6'd0, 1'b0}});
    r.sp = 16'd20;
    r.sa = 32'hC0A80155;
    directed.push_back('{r, 1'b0, z});
    r.sa = 32'hC0A800FF;
    r.proto = 8'd0;
    directed.push_back('{r, 1'b0, z});

    foreach (directed[i]) issue(directed[i].req, directed[i].has_exp, directed[i].exp);
    drain();

    write_cfg(CfgActiveChains, 4'd8);
    write_cfg(CfgDefaultActions, 24'hFFFFFF);
    fill_chain(7, 64);
    r = '{ModeCount, 3'd7, '0, WordSrc, 64'd100, '0, '0, '0, '0, '0};
    issue(r, 1'b0, z);
    r = '{ModeClass, 3'd7, '0, WordSrc, '0, '0, '0, 16'd63, 16'd0, 8'd0};
    issue(r, 1'b0, z);
    r.sp = 16'hFFFF;
    issue(r, 1'b0, z);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_cfg(CfgActiveChains, 4'd8);
          write_cfg(CfgDefaultActions, 24'($urandom));
        end
        1: begin
          write_cfg(CfgActiveChains, 4'd1);
          write_cfg(CfgDefaultActions, 24'h0);
        end
        2: begin
          write_cfg(CfgActiveChains, 4'hF);
          write_cfg(CfgDefaultActions, 24'($urandom));
        end
        default: begin
          write_cfg(CfgActiveChains, 4'($urandom_range(2, 7)));
          write_cfg(CfgDefaultActions, 24'($urandom));
          quiet = 1'b1;
        end
      endcase
      for (int k = 0; k < 190; k++) begin
        issue(rand_request(chain_limit == 0 ? 1 : (chain_limit > 8 ? 8 : chain_limit)),
              1'b0, z);
        if (phase == 0 && k == 100) drain();
      end
      drain();
    end

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

[files.f]
rtl/fmprc_pkg.sv
rtl/fmprc_datapath.sv
rtl/fmprc_ctrl.sv
rtl/first_match_packet_rule_classifier.sv
rtl/fmprc_checker.sv
dv/testbench.sv
